// File: rtl/hsv_pkg.sv
// Package for the HSV to RGB converter: widths, sector codes and the
// transaction structs shared by the front end, queue, back end and top level.
`timescale 1ns / 1ps

package hsv_pkg;

  localparam int unsigned HUE_BITS    = 16;
  localparam int unsigned COLOR_BITS  = 8;
  localparam int unsigned PROD_BITS   = 2 * COLOR_BITS;
  localparam int unsigned SCALE_BITS  = HUE_BITS + 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    SECTOR_RY = 3'd0,
    SECTOR_YG = 3'd1,
    SECTOR_GC = 3'd2,
    SECTOR_CB = 3'd3,
    SECTOR_BM = 3'd4,
    SECTOR_MR = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HUE_BITS-1:0]   hue;
    logic [COLOR_BITS-1:0] saturation;
    logic [COLOR_BITS-1:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } hsv_out_t;

  typedef struct packed {
    logic [PROD_BITS-1:0]  chroma_prod;
    logic [COLOR_BITS-1:0] brightness;
    sector_e               sector;
    logic [SCALE_BITS-1:0] scale;
  } hsv_job_t;

endpackage

// File: rtl/hsv_front.sv
// Front end: splits the hue into sector and blend scale, forms v*s.
// Depends on hsv_pkg.
`timescale 1ns / 1ps

module hsv_front (
  input  hsv_pkg::hsv_in_t  pixel_i,
  output hsv_pkg::hsv_job_t job_o
);
  import hsv_pkg::*;

  logic [HUE_BITS+2:0] hue6;
  logic [HUE_BITS-1:0] frac;

  assign hue6 = ({3'b000, pixel_i.hue} << 2) + ({3'b000, pixel_i.hue} << 1);
  assign frac = hue6[HUE_BITS-1:0];

  always_comb begin
    job_o.chroma_prod = PROD_BITS'(pixel_i.saturation) * PROD_BITS'(pixel_i.brightness);
    job_o.brightness  = pixel_i.brightness;
    job_o.sector      = sector_e'(hue6[HUE_BITS+2:HUE_BITS]);
    // odd sectors blend with (1 - f)
    if (hue6[HUE_BITS]) begin
      job_o.scale = {1'b1, {HUE_BITS{1'b0}}} - {1'b0, frac};
    end else begin
      job_o.scale = {1'b0, frac};
    end
  end

endmodule

// File: rtl/hsv_queue.sv
// Short FIFO between front end and back end.
// Depends on hsv_pkg.
`timescale 1ns / 1ps

module hsv_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hsv_pkg::hsv_job_t data_i,
  input  logic              pop_i,
  output hsv_pkg::hsv_job_t data_o,
  output logic              empty_o,
  output logic              full_o
);
  import hsv_pkg::*;

  localparam int unsigned PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);

  hsv_job_t             mem_q [QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign empty_o = (count_q == CntBits'(0));
  assign full_o  = (count_q == CntBits'(QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntBits'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/hsv_back.sv
// Back end: chroma by divide-by-max, blend multiply, sector permutation
// and offset add, three register stages. Depends on hsv_pkg.
`timescale 1ns / 1ps

module hsv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  hsv_pkg::hsv_job_t job_i,
  output logic              valid_o,
  output hsv_pkg::hsv_out_t rgb_o
);
  import hsv_pkg::*;

  localparam int unsigned MultBits = COLOR_BITS + SCALE_BITS;
  localparam int unsigned RoundBias = (1 << (COLOR_BITS - 1)) - 1;

  // stage 1
  logic                  s1_valid_q;
  logic [COLOR_BITS-1:0] s1_chroma_q, s1_chroma_d;
  logic [COLOR_BITS-1:0] s1_bright_q;
  sector_e               s1_sector_q;
  logic [SCALE_BITS-1:0] s1_scale_q;
  // stage 2
  logic                  s2_valid_q;
  logic [MultBits-1:0]   s2_mult_q;
  logic [COLOR_BITS-1:0] s2_chroma_q;
  logic [COLOR_BITS-1:0] s2_offset_q;
  sector_e               s2_sector_q;
  // stage 3
  logic                  out_valid_q;
  hsv_out_t              rgb_q, rgb_d;

  logic [PROD_BITS:0]    div_num;
  logic [PROD_BITS:0]    div_sum;
  logic [MultBits-1:0]   mult_rnd;
  logic [COLOR_BITS-1:0] blend;

  // round(p / MAX) == floor((p + MAX/2) / MAX), divide by 2^N-1 via shift-add
  always_comb begin
    div_num     = {1'b0, job_i.chroma_prod} + (PROD_BITS + 1)'(RoundBias);
    div_sum     = div_num + (div_num >> COLOR_BITS) + (PROD_BITS + 1)'(1);
    s1_chroma_d = div_sum[COLOR_BITS +: COLOR_BITS];
  end

  always_comb begin
    mult_rnd = s2_mult_q + MultBits'(1 << (HUE_BITS - 1));
    blend    = mult_rnd[HUE_BITS +: COLOR_BITS];
    rgb_d    = '0;
    case (s2_sector_q)
      SECTOR_RY: begin
        rgb_d.red   = s2_chroma_q;
        rgb_d.green = blend;
      end
      SECTOR_YG: begin
        rgb_d.red   = blend;
        rgb_d.green = s2_chroma_q;
      end
      SECTOR_GC: begin
        rgb_d.green = s2_chroma_q;
        rgb_d.blue  = blend;
      end
      SECTOR_CB: begin
        rgb_d.green = blend;
        rgb_d.blue  = s2_chroma_q;
      end
      SECTOR_BM: begin
        rgb_d.red   = blend;
        rgb_d.blue  = s2_chroma_q;
      end
      default: begin
        rgb_d.red   = s2_chroma_q;
        rgb_d.blue  = blend;
      end
    endcase
    rgb_d.red   = rgb_d.red + s2_offset_q;
    rgb_d.green = rgb_d.green + s2_offset_q;
    rgb_d.blue  = rgb_d.blue + s2_offset_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_chroma_q <= s1_chroma_d;
    s1_bright_q <= job_i.brightness;
    s1_sector_q <= job_i.sector;
    s1_scale_q  <= job_i.scale;
    s2_mult_q   <= MultBits'(s1_chroma_q) * MultBits'(s1_scale_q);
    s2_chroma_q <= s1_chroma_q;
    s2_offset_q <= s1_bright_q - s1_chroma_q;
    s2_sector_q <= s1_sector_q;
    rgb_q       <= rgb_d;
  end

  assign valid_o = out_valid_q;
  assign rgb_o   = rgb_q;

endmodule

// File: rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter top level: front end, job FIFO and back end.
// Depends on hsv_pkg, hsv_front, hsv_queue and hsv_back.
`timescale 1ns / 1ps

// Converts one pixel per clock. A transaction is taken on a rising edge with
// start_i high and busy_o low; its RGB result is presented on rgb_o with
// valid_o high for one cycle, after passing through the FIFO slot, then the
// chroma, blend-multiply and output registers of the back end. The back end
// pops the FIFO whenever it is not empty and results cannot be held off, so
// busy_o only rises if the FIFO fills, which a steady one-per-clock stream
// never does. Results come out in acceptance order.

module hsv_to_rgb_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  hsv_pkg::hsv_in_t  pixel_i,
  output logic              valid_o,
  output hsv_pkg::hsv_out_t rgb_o
);
  import hsv_pkg::*;

  hsv_job_t front_job;
  hsv_job_t queue_job;
  logic     queue_empty;
  logic     queue_full;
  logic     accept;

  assign accept = start_i && !queue_full;
  assign busy_o = queue_full;

  hsv_front u_front (
    .pixel_i (pixel_i),
    .job_o   (front_job)
  );

  hsv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_job),
    .pop_i   (!queue_empty),
    .data_o  (queue_job),
    .empty_o (queue_empty),
    .full_o  (queue_full)
  );

  hsv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!queue_empty),
    .job_i   (queue_job),
    .valid_o (valid_o),
    .rgb_o   (rgb_o)
  );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for hsv_to_rgb_converter: drives pixels through the
// start/busy handshake and checks every RGB result against an in-bench predictor.
// Depends on hsv_pkg and the hsv_to_rgb_converter RTL.
`timescale 1ns / 1ps

module testbench;
  import hsv_pkg::*;

  localparam int unsigned COLOR_MAX   = (1 << COLOR_BITS) - 1;
  localparam int unsigned HUE_ONE     = 1 << HUE_BITS;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 10;
  localparam int unsigned MAX_SHOWN   = 10;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  hsv_in_t  pixel_i = '0;
  logic     busy_o;
  logic     valid_o;
  hsv_out_t rgb_o;

  hsv_out_t    expected_rgb[$];
  int unsigned rgb_mismatches = 0;
  int unsigned pixels_sent    = 0;
  int unsigned pixels_checked = 0;
  int unsigned cycle_count    = 0;
  bit          gaps_on        = 1'b1;

  hsv_to_rgb_converter u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .pixel_i (pixel_i),
    .valid_o (valid_o),
    .rgb_o   (rgb_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("hsv_to_rgb_converter verification failed");
      $finish;
    end
  end

  function automatic hsv_out_t predict_rgb(hsv_in_t px);
    int unsigned chroma, hue6, frac, weight, blend, offset, r, g, b;
    sector_e     sector;
    hsv_out_t    rgb;
    chroma = (2 * int'(px.brightness) * int'(px.saturation) + COLOR_MAX) / (2 * COLOR_MAX);
    hue6   = int'(px.hue) * 6;
    sector = sector_e'(hue6 >> HUE_BITS);
    frac   = hue6 & (HUE_ONE - 1);
    weight = sector[0] ? HUE_ONE - frac : frac;
    blend  = (chroma * weight + (HUE_ONE >> 1)) >> HUE_BITS;
    offset = int'(px.brightness) - chroma;
    case (sector)
      SECTOR_RY: begin r = chroma; g = blend;  b = 0;      end
      SECTOR_YG: begin r = blend;  g = chroma; b = 0;      end
      SECTOR_GC: begin r = 0;      g = chroma; b = blend;  end
      SECTOR_CB: begin r = 0;      g = blend;  b = chroma; end
      SECTOR_BM: begin r = blend;  g = 0;      b = chroma; end
      default: begin r = chroma; g = 0;      b = blend;  end
    endcase
    rgb.red   = COLOR_BITS'(r + offset);
    rgb.green = COLOR_BITS'(g + offset);
    rgb.blue  = COLOR_BITS'(b + offset);
    return rgb;
  endfunction

  function automatic hsv_in_t make_pixel(int unsigned hue, int unsigned sat, int unsigned val);
    hsv_in_t px;
    px.hue        = HUE_BITS'(hue);
    px.saturation = COLOR_BITS'(sat);
    px.brightness = COLOR_BITS'(val);
    return px;
  endfunction

  function automatic int unsigned pick_color();
    int unsigned corners[4] = '{0, 1, COLOR_MAX - 1, COLOR_MAX};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 3)];
    return $urandom_range(0, COLOR_MAX);
  endfunction

  function automatic hsv_in_t random_pixel();
    int unsigned hue;
    if ($urandom_range(0, 9) == 0)
      hue = ($urandom_range(1, 5) * HUE_ONE + 5) / 6 - $urandom_range(0, 1);
    else
      hue = $urandom_range(0, HUE_ONE - 1);
    return make_pixel(hue, pick_color(), pick_color());
  endfunction

  task automatic note_mismatch(string msg);
    rgb_mismatches++;
    if (rgb_mismatches <= MAX_SHOWN) $display("MISMATCH: %s", msg);
  endtask

  // one transaction; start_i stays high on return
  task automatic send_pixel(hsv_in_t px);
    if (gaps_on && $urandom_range(0, 99) < 8) begin
      start_i <= 1'b0;
      pixel_i <= random_pixel();
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    expected_rgb.push_back(predict_rgb(px));
    pixels_sent++;
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : rgb_check
    hsv_out_t want_rgb;
    if (rst_ni && valid_o === 1'b1) begin
      if (expected_rgb.size() == 0) begin
        note_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                rgb_o.red, rgb_o.green, rgb_o.blue));
      end else begin
        want_rgb = expected_rgb.pop_front();
        pixels_checked++;
        if (rgb_o.red !== want_rgb.red || rgb_o.green !== want_rgb.green ||
            rgb_o.blue !== want_rgb.blue) begin
          note_mismatch($sformatf("exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                  want_rgb.red, want_rgb.green, want_rgb.blue,
                                  rgb_o.red, rgb_o.green, rgb_o.blue));
        end
      end
    end else if (rst_ni && valid_o !== 1'b0) begin
      note_mismatch("valid_o is unknown");
    end
  end

  task automatic test_corners();
    send_pixel(make_pixel(0, COLOR_MAX, COLOR_MAX));
    send_pixel(make_pixel(HUE_ONE - 1, COLOR_MAX, COLOR_MAX));
    send_pixel(make_pixel(HUE_ONE - 1, COLOR_MAX, COLOR_MAX - 1));
    send_pixel(make_pixel(0, 0, 0));
    send_pixel(make_pixel(HUE_ONE - 1, 0, COLOR_MAX));
    send_pixel(make_pixel(12345, COLOR_MAX, 0));
    send_pixel(make_pixel(HUE_ONE / 2, COLOR_MAX, COLOR_MAX / 2 + 1));
    send_pixel(make_pixel(HUE_ONE / 4, 1, COLOR_MAX));
    send_pixel(make_pixel(HUE_ONE / 3, COLOR_MAX, 1));
    send_pixel(make_pixel(21845, 170, 85));
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // sector edges; the edge into SECTOR_CB is an odd sector at zero fraction
  task automatic test_sector_edges();
    int unsigned edge_hue;
    for (int unsigned k = 1; k <= 5; k++) begin
      edge_hue = (k * HUE_ONE + 5) / 6;
      send_pixel(make_pixel(edge_hue - 1, COLOR_MAX, COLOR_MAX));
      send_pixel(make_pixel(edge_hue, COLOR_MAX, COLOR_MAX));
    end
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_hue_only(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_pixel(make_pixel($urandom_range(0, HUE_ONE - 1), COLOR_MAX, COLOR_MAX));
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_drain_pause();
    for (int unsigned i = 0; i < 20; i++) send_pixel(random_pixel());
    drain_results();
    for (int unsigned i = 0; i < 10; i++) send_pixel(random_pixel());
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_random_stream(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      gaps_on = !(i >= 600 && i < 1000);
      if (i == 1200) drain_results();
      send_pixel(random_pixel());
    end
    gaps_on = 1'b1;
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_sector_edges();
    test_hue_only(60);
    test_drain_pause();
    test_random_stream(1750);
    while (expected_rgb.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Covered %0d pixels (%0d results checked): color corners, sector edges,",
             pixels_sent, pixels_checked);
    $display("hue-only sweep, a drained pause and a random stream with and without gaps.");
    if (rgb_mismatches == 0 && expected_rgb.size() == 0) begin
      $display("hsv_to_rgb_converter verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", rgb_mismatches, expected_rgb.size());
      $display("hsv_to_rgb_converter verification failed");
    end
    $finish;
  end

endmodule
